// ===== hw/rtl/aer_event_word_decoder_packetizer_top_macros.svh =====
// assertion macros for the event word decoder
`ifndef AER_EVENT_WORD_DECODER_PACKETIZER_TOP_MACROS_SVH
`define AER_EVENT_WORD_DECODER_PACKETIZER_TOP_MACROS_SVH

// condition implies consequence in the same cycle
`define AEWDP_ASSERT_SAME(label, cond, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (cons)) \
        else $error("aewdp check failed");

// condition implies consequence in the next cycle
`define AEWDP_ASSERT_NEXT(label, cond, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (cons)) \
        else $error("aewdp check failed");

`endif

// ===== hw/rtl/aewdp_pkg.sv =====
package aewdp_pkg;

    // event kinds as carried on the output tuser
    typedef enum logic [1:0] {
        KIND_POLARITY = 2'd0,
        KIND_TRIGGER  = 2'd1,
        KIND_WRAP     = 2'd2,
        KIND_RESET    = 2'd3
    } t_kind;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_POL_MAX_EVENTS  = 2'd0,
        CFG_POL_MAX_SPAN    = 2'd1,
        CFG_SPEC_MAX_EVENTS = 2'd2,
        CFG_SPEC_MAX_SPAN   = 2'd3
    } t_cfg_index;

    localparam int unsigned FILL_W  = 16;
    localparam int unsigned TIME_W  = 32;
    localparam int unsigned WRAP_W  = 18;
    localparam int unsigned TICK_W  = 14;

    localparam logic [FILL_W-1:0] POL_MAX_EVENTS_RST  = 16'd4096;
    localparam logic [TIME_W-1:0] POL_MAX_SPAN_RST    = 32'd5000;
    localparam logic [FILL_W-1:0] SPEC_MAX_EVENTS_RST = 16'd128;
    localparam logic [TIME_W-1:0] SPEC_MAX_SPAN_RST   = 32'd1000;

    localparam logic [6:0] X_MIRROR = 7'd127;

    // per-packet update request
    typedef struct packed {
        logic              step;
        logic              enter;
        logic              force_close;
        logic [TIME_W-1:0] stamp;
    } t_pkt_req;

    // one decoded result
    typedef struct packed {
        logic              back;
        logic              close_spec;
        logic              close_pol;
        logic              up;
        logic [6:0]        py;
        logic [6:0]        px;
        logic [TIME_W-1:0] stamp;
        t_kind             kind;
    } t_result;

endpackage

// ===== hw/rtl/aewdp_packet.sv =====
module aewdp_packet
    import aewdp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_pkt_req          i_req,
    input  logic [FILL_W-1:0] i_max_events,
    input  logic [TIME_W-1:0] i_max_span,
    output logic              o_close
);

    logic [FILL_W-1:0] r_fill;
    logic [FILL_W-1:0] r_cap;
    logic [TIME_W-1:0] r_first;
    logic [TIME_W-1:0] r_last;

    logic [FILL_W-1:0] n_fill_add;
    logic [FILL_W-1:0] n_cap;
    logic [TIME_W-1:0] n_first;
    logic [TIME_W-1:0] n_last;
    logic [TIME_W-1:0] span;
    logic              empty;

    // capacity latched at packet start, event joins, then close check
    always_comb begin
        empty      = (r_fill == '0);
        n_cap      = empty ? i_max_events : r_cap;
        n_fill_add = i_req.enter ? r_fill + FILL_W'(1) : r_fill;
        n_first    = (i_req.enter && empty) ? i_req.stamp : r_first;
        n_last     = i_req.enter ? i_req.stamp : r_last;
        span       = n_last - n_first;
        o_close    = i_req.force_close || (n_fill_add >= n_cap) ||
                     ((n_fill_add > FILL_W'(1)) && (span >= i_max_span));
    end

    // fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (i_req.step) begin
            r_fill <= o_close ? '0 : n_fill_add;
        end
    end

    // packet bookkeeping, only read once the packet holds events
    always_ff @(posedge i_clk) begin
        if (i_req.step) begin
            r_cap   <= n_cap;
            r_first <= n_first;
            r_last  <= n_last;
        end
    end

endmodule

// ===== hw/rtl/aer_event_word_decoder_packetizer_top.sv =====
// an accepted result is registered in r_out, or in r_skid while r_out waits
// throughput: one request per cycle while the skid register is empty, which keeps tready
//   high while one result waits; the decode and packet checks are combinational logic
// a wrap word that does not roll the wrap counter over produces no result
// synchronous active-low reset clears counters, fill counts and result valids
//   and loads the default configuration values
`include "aer_event_word_decoder_packetizer_top_macros.svh"

module aer_event_word_decoder_packetizer_top
    import aewdp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    // slave side
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // address_half[15:0], time_half[31:16]
    // master side
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [55:0] o_m_tdata,   // event_time[31:0], pixel_x[38:32], pixel_y[45:39],
                                     // brightness_up[46], close_polarity_packet[47],
                                     // close_special_packet[48], time_went_backwards[49]
    output logic [1:0]  o_m_tuser    // event_kind[1:0]
);

    // configuration registers
    logic [FILL_W-1:0] r_pol_max_events;
    logic [TIME_W-1:0] r_pol_max_span;
    logic [FILL_W-1:0] r_spec_max_events;
    logic [TIME_W-1:0] r_spec_max_span;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pol_max_events  <= POL_MAX_EVENTS_RST;
            r_pol_max_span    <= POL_MAX_SPAN_RST;
            r_spec_max_events <= SPEC_MAX_EVENTS_RST;
            r_spec_max_span   <= SPEC_MAX_SPAN_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_POL_MAX_EVENTS:  r_pol_max_events  <= i_cfg_data[FILL_W-1:0];
                CFG_POL_MAX_SPAN:    r_pol_max_span    <= i_cfg_data;
                CFG_SPEC_MAX_EVENTS: r_spec_max_events <= i_cfg_data[FILL_W-1:0];
                CFG_SPEC_MAX_SPAN:   r_spec_max_span   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // handshake
    logic r_out_valid;
    logic r_skid_valid;
    logic accept;
    logic produce;
    logic take;

    assign o_s_tready = !r_skid_valid;
    assign accept     = i_s_tvalid && o_s_tready;
    assign take       = r_out_valid && i_m_tready;

    // word decode
    logic [15:0]       addr_half;
    logic [15:0]       time_half;
    logic              wrap_word;
    logic              rst_word;
    logic [WRAP_W-1:0] wrap_next;
    logic              emit;
    logic [TIME_W-1:0] stamp_calc;
    logic [WRAP_W-1:0] r_wrap_count;
    logic [TIME_W-1:0] r_prev_time;
    t_result           res;

    assign addr_half = i_s_tdata[15:0];
    assign time_half = i_s_tdata[31:16];

    always_comb begin
        wrap_word  = time_half[15];
        rst_word   = !time_half[15] && time_half[14];
        wrap_next  = r_wrap_count + WRAP_W'(1);
        emit       = !wrap_word || (wrap_next == '0);
        stamp_calc = TIME_W'(time_half) + {r_wrap_count, {TICK_W{1'b0}}};
        res        = '0;
        if (wrap_word) begin
            res.kind  = KIND_WRAP;
            res.stamp = '1;
        end else if (rst_word) begin
            res.kind  = KIND_RESET;
            res.stamp = '1;
        end else begin
            res.stamp = stamp_calc;
            res.back  = (stamp_calc < r_prev_time);
            if (addr_half[15]) begin
                res.kind = KIND_TRIGGER;
            end else begin
                res.kind = KIND_POLARITY;
                res.px   = X_MIRROR - addr_half[7:1];
                res.py   = addr_half[14:8];
                res.up   = !addr_half[0];
            end
        end
    end

    assign produce = accept && emit;

    // wrap counter and last decoded time
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wrap_count <= '0;
            r_prev_time  <= '0;
        end else if (accept) begin
            if (wrap_word) begin
                r_wrap_count <= wrap_next;
                if (emit) begin
                    r_prev_time <= '0;
                end
            end else if (rst_word) begin
                r_wrap_count <= '0;
                r_prev_time  <= '0;
            end else begin
                r_prev_time <= stamp_calc;
            end
        end
    end

    // packet trackers
    t_pkt_req pol_req;
    t_pkt_req spec_req;
    logic     pol_close;
    logic     spec_close;

    always_comb begin
        pol_req.step         = produce;
        pol_req.enter        = (res.kind == KIND_POLARITY);
        pol_req.force_close  = wrap_word || rst_word;
        pol_req.stamp        = res.stamp;
        spec_req             = pol_req;
        spec_req.enter       = (res.kind != KIND_POLARITY);
    end

    aewdp_packet u_pol_packet (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (pol_req),
        .i_max_events (r_pol_max_events),
        .i_max_span   (r_pol_max_span),
        .o_close      (pol_close)
    );

    aewdp_packet u_spec_packet (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (spec_req),
        .i_max_events (r_spec_max_events),
        .i_max_span   (r_spec_max_span),
        .o_close      (spec_close)
    );

    t_result full_res;

    always_comb begin
        full_res            = res;
        full_res.close_pol  = pol_close;
        full_res.close_spec = spec_close;
    end

    // output register with skid stage
    t_result r_out;
    t_result r_skid;
    logic    n_out_valid;
    logic    n_skid_valid;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        if (take) begin
            n_out_valid  = r_skid_valid;
            n_skid_valid = 1'b0;
        end
        if (produce) begin
            if (!r_out_valid || take) begin
                n_out_valid = 1'b1;
            end else begin
                n_skid_valid = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (produce && (!r_out_valid || take)) begin
            r_out <= full_res;
        end else if (take && r_skid_valid) begin
            r_out <= r_skid;
        end
        if (produce && r_out_valid && !take) begin
            r_skid <= full_res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out.kind;
    assign o_m_tdata  = {6'b0, r_out.back, r_out.close_spec, r_out.close_pol, r_out.up,
                         r_out.py, r_out.px, r_out.stamp};

    // checks
    logic out_marker;
    logic marker_closed;
    logic wrap_state_clear;

    assign out_marker       = r_out_valid && r_out.kind[1];
    assign marker_closed    = (r_out.stamp == '1) && r_out.close_pol && r_out.close_spec;
    assign wrap_state_clear = (r_wrap_count == '0) && (r_prev_time == '0);

    `AEWDP_ASSERT_SAME(a_skid_behind_out, r_skid_valid, r_out_valid)
    `AEWDP_ASSERT_SAME(a_marker_closes_all, out_marker, marker_closed)
    `AEWDP_ASSERT_NEXT(a_reset_word_clears, accept && rst_word, wrap_state_clear)
    `AEWDP_ASSERT_NEXT(a_drain_empties, take && !r_skid_valid && !produce, !r_out_valid)

endmodule
